[rtl/gec_pkg.sv]
package gec_pkg;

  localparam logic [1:0] OP_EVENT   = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_DISCARD = 2'd2;

  localparam logic [1:0]  PRIO_CRIT   = 2'd3;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
  localparam int          MAX_RESULTS = 16;
  localparam int          NW          = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [1:0]  operation;
    logic        has_group;
    logic [7:0]  group_id;
    logic [1:0]  priority_req;
    logic [15:0] window_ticks;
    logic [15:0] message_tag;
  } in_t;

  typedef struct packed {
    logic [15:0] message_tag_res;
    logic [1:0]  priority_res;
    logic [7:0]  group_id_res;
    logic [15:0] burst_count;
    logic        passed_through;
    logic        last;
  } out_t;

  typedef enum logic [1:0] {
    K_PASS    = 2'd0,
    K_EVENT   = 2'd1,
    K_TICK    = 2'd2,
    K_DISCARD = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t kind;
    in_t   item;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  group;
    logic [15:0] remaining;
    logic [15:0] count;
    logic [15:0] tag;
    logic [1:0]  prio;
  } slot_t;

endpackage

[rtl/gec_ram.sv]
module gec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/gec_front.sv]
module gec_front
  import gec_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  in_t  in_data,
  output logic busy,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic q_pop
);

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cmd;

  // sort the word into pass-through, coalesce, tick or discard; an unused operation is not pushed
  always_comb begin
    cmd      = '{kind: K_PASS, item: in_data};
    push     = 1'b0;
    unique case (in_data.operation)
      OP_EVENT: begin
        push = 1'b1;
        if (!in_data.has_group || in_data.window_ticks == 16'd0 ||
            in_data.priority_req == PRIO_CRIT) begin
          cmd.kind = K_PASS;
          if (!in_data.has_group) begin
            cmd.item.group_id = 8'd0;
          end
        end else begin
          cmd.kind = K_EVENT;
        end
      end
      OP_TICK: begin
        push     = 1'b1;
        cmd.kind = K_TICK;
      end
      OP_DISCARD: begin
        push     = 1'b1;
        cmd.kind = K_DISCARD;
      end
      default: push = 1'b0;
    endcase
    push = push && start && !busy;
  end

  assign busy    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cmd;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= 2'd2) && !(q_pop && cnt_r == 2'd0))
    else $error("queue fill out of range or pop from empty queue");

endmodule

[rtl/gec_back.sv]
module gec_back
  import gec_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic out_valid,
  output out_t out_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int SW = $bits(slot_t);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t          state_r, state_nxt;
  cmd_t            cur_r, cur_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            rv_r, rv_nxt;
  logic [IW-1:0]   ridx_r, ridx_nxt;
  logic [SLOTS-1:0] open_r, open_nxt;
  logic            hit_v_r, hit_v_nxt;
  logic [IW-1:0]   hit_idx_r, hit_idx_nxt;
  slot_t           hit_d_r, hit_d_nxt;
  logic            free_v_r, free_v_nxt;
  logic [IW-1:0]   free_idx_r, free_idx_nxt;
  logic            hold_v_r, hold_v_nxt;
  out_t            hold_r, hold_nxt;
  logic [NW-1:0]   n_r, n_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_r, out_nxt;

  logic            we, re;
  logic [IW-1:0]   waddr, raddr;
  slot_t           wdata, rdata;
  logic [SW-1:0]   rdata_raw;

  gec_ram #(
    .WIDTH (SW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rdata = slot_t'(rdata_raw);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    rv_nxt        = rv_r;
    ridx_nxt      = ridx_r;
    open_nxt      = open_r;
    hit_v_nxt     = hit_v_r;
    hit_idx_nxt   = hit_idx_r;
    hit_d_nxt     = hit_d_r;
    free_v_nxt    = free_v_r;
    free_idx_nxt  = free_idx_r;
    hold_v_nxt    = hold_v_r;
    hold_nxt      = hold_r;
    n_nxt         = n_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    we            = 1'b0;
    waddr         = ridx_r;
    wdata         = rdata;
    re            = 1'b0;
    raddr         = cnt_r[IW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_cmd;
          unique case (q_cmd.kind)
            K_PASS: begin
              out_valid_nxt           = 1'b1;
              out_nxt.message_tag_res = q_cmd.item.message_tag;
              out_nxt.priority_res    = q_cmd.item.priority_req;
              out_nxt.group_id_res    = q_cmd.item.group_id;
              out_nxt.burst_count     = 16'd1;
              out_nxt.passed_through  = 1'b1;
              out_nxt.last            = 1'b1;
            end
            K_DISCARD: open_nxt = '0;
            K_EVENT, K_TICK: begin
              state_nxt  = ST_SCAN;
              cnt_nxt    = '0;
              rv_nxt     = 1'b0;
              hit_v_nxt  = 1'b0;
              free_v_nxt = 1'b0;
              hold_v_nxt = 1'b0;
              n_nxt      = '0;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // read side walks the slots, data is handled in the following cycle
        if (cnt_r < CW'(SLOTS)) begin
          re       = 1'b1;
          rv_nxt   = 1'b1;
          ridx_nxt = cnt_r[IW-1:0];
          cnt_nxt  = cnt_r + CW'(1);
        end else begin
          rv_nxt = 1'b0;
        end

        if (rv_r) begin
          if (cur_r.kind == K_TICK) begin
            if (open_r[ridx_r]) begin
              if (rdata.remaining > 16'd1) begin
                we              = 1'b1;
                wdata.remaining = rdata.remaining - 16'd1;
              end else if (n_r < NW'(MAX_RESULTS)) begin
                open_nxt[ridx_r]         = 1'b0;
                n_nxt                    = n_r + NW'(1);
                hold_v_nxt               = 1'b1;
                hold_nxt.message_tag_res = rdata.tag;
                hold_nxt.priority_res    = rdata.prio;
                hold_nxt.group_id_res    = rdata.group;
                hold_nxt.burst_count     = rdata.count;
                hold_nxt.passed_through  = 1'b0;
                hold_nxt.last            = 1'b0;
                // a newer expiry shows the held word is not the final one
                if (hold_v_r) begin
                  out_valid_nxt = 1'b1;
                  out_nxt       = hold_r;
                end
              end
            end
          end else begin
            if (!hit_v_r && open_r[ridx_r] && rdata.group == cur_r.item.group_id) begin
              hit_v_nxt   = 1'b1;
              hit_idx_nxt = ridx_r;
              hit_d_nxt   = rdata;
            end
            if (!free_v_r && !open_r[ridx_r]) begin
              free_v_nxt   = 1'b1;
              free_idx_nxt = ridx_r;
            end
          end
        end

        if (!(cnt_r < CW'(SLOTS)) && !rv_r) begin
          state_nxt = ST_IDLE;
          if (cur_r.kind == K_TICK) begin
            if (hold_v_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = hold_r;
              out_nxt.last  = 1'b1;
              hold_v_nxt    = 1'b0;
            end
          end else if (hit_v_r) begin
            we    = 1'b1;
            waddr = hit_idx_r;
            wdata = hit_d_r;
            if (hit_d_r.count != COUNT_MAX) begin
              wdata.count = hit_d_r.count + 16'd1;
            end
            if (cur_r.item.priority_req >= hit_d_r.prio) begin
              wdata.tag  = cur_r.item.message_tag;
              wdata.prio = cur_r.item.priority_req;
            end
          end else if (free_v_r) begin
            we                   = 1'b1;
            waddr                = free_idx_r;
            wdata.group          = cur_r.item.group_id;
            wdata.remaining      = cur_r.item.window_ticks;
            wdata.count          = 16'd1;
            wdata.tag            = cur_r.item.message_tag;
            wdata.prio           = cur_r.item.priority_req;
            open_nxt[free_idx_r] = 1'b1;
          end else begin
            // every slot taken, the event goes out on its own
            out_valid_nxt           = 1'b1;
            out_nxt.message_tag_res = cur_r.item.message_tag;
            out_nxt.priority_res    = cur_r.item.priority_req;
            out_nxt.group_id_res    = cur_r.item.group_id;
            out_nxt.burst_count     = 16'd1;
            out_nxt.passed_through  = 1'b1;
            out_nxt.last            = 1'b1;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      open_r      <= '0;
      hit_v_r     <= 1'b0;
      free_v_r    <= 1'b0;
      hold_v_r    <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rv_r        <= rv_nxt;
      open_r      <= open_nxt;
      hit_v_r     <= hit_v_nxt;
      free_v_r    <= free_v_nxt;
      hold_v_r    <= hold_v_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    ridx_r     <= ridx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_d_r    <= hit_d_nxt;
    free_idx_r <= free_idx_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_pass_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.passed_through |-> out_r.last)
    else $error("pass-through word without last");

  a_burst_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.burst_count != 16'd0)
    else $error("word with zero burst count");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(MAX_RESULTS))
    else $error("too many expiries emitted for one tick");

  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rv_r |-> state_r == ST_SCAN && !q_pop)
    else $error("slot read pending outside scan");

endmodule

[rtl/grouped_event_coalescer.sv]
// Event coalescer. Words are offered with start and taken when busy is low; a two-word
// queue sits in front of the slot engine, so busy only rises when that queue is full.
// An unused operation is dropped at the queue and never reaches the engine; a discard and
// an event that goes straight through are handled without a slot walk. A coalescing event
// or a tick walks the slot memory one slot per cycle through its single read port.
// Results come out one per cycle on out_valid, one cycle wide, and cannot be held off by
// the receiver; the expiries of a tick appear while the walk goes on, the last one flagged
// at its end.
module grouped_event_coalescer
  import gec_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  gec_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .busy    (busy),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  gec_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[test/grouped_event_coalescer_test.sv]
`timescale 1ns / 100ps

module grouped_event_coalescer_test
  import gec_pkg::*;
();

  localparam int SLOTS = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 200_000;
  localparam int DRAIN_CYCLES = 4 * SLOTS + 16;
  localparam int RANDOM_WORDS = 350;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  // predicted slot table
  bit    slot_live [SLOTS];
  slot_t slot_st [SLOTS];

  out_t due_bursts[$];
  int   bad_words;

  grouped_event_coalescer #(
    .SLOTS(SLOTS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  function automatic in_t mk_word(input logic [1:0] op, input logic hg, input logic [7:0] grp,
                                  input logic [1:0] pr, input logic [15:0] win,
                                  input logic [15:0] tag);
    in_t w;
    w.operation = op;
    w.has_group = hg;
    w.group_id = grp;
    w.priority_req = pr;
    w.window_ticks = win;
    w.message_tag = tag;
    return w;
  endfunction

  // works out what the block emits for one accepted word and updates the slot table
  task automatic coalesce(input in_t w);
    int   hit;
    int   fre;
    int   i;
    out_t r;
    out_t batch[$];
    hit = -1;
    fre = -1;
    r = '0;
    case (w.operation)
      OP_EVENT: begin
        if (!w.has_group || w.window_ticks == 16'd0 || w.priority_req == PRIO_CRIT) begin
          r.message_tag_res = w.message_tag;
          r.priority_res = w.priority_req;
          r.group_id_res = w.has_group ? w.group_id : 8'd0;
          r.burst_count = 16'd1;
          r.passed_through = 1'b1;
          r.last = 1'b1;
          due_bursts.push_back(r);
        end else begin
          for (i = 0; i < SLOTS; i++) begin
            if (slot_live[i]) begin
              if (hit < 0 && slot_st[i].group == w.group_id) hit = i;
            end else if (fre < 0) begin
              fre = i;
            end
          end
          if (hit >= 0) begin
            if (slot_st[hit].count != COUNT_MAX) slot_st[hit].count++;
            if (w.priority_req >= slot_st[hit].prio) begin
              slot_st[hit].tag = w.message_tag;
              slot_st[hit].prio = w.priority_req;
            end
          end else if (fre >= 0) begin
            slot_live[fre] = 1'b1;
            slot_st[fre].group = w.group_id;
            slot_st[fre].remaining = w.window_ticks;
            slot_st[fre].count = 16'd1;
            slot_st[fre].tag = w.message_tag;
            slot_st[fre].prio = w.priority_req;
          end else begin
            // table full, the new group goes straight out
            r.message_tag_res = w.message_tag;
            r.priority_res = w.priority_req;
            r.group_id_res = w.group_id;
            r.burst_count = 16'd1;
            r.passed_through = 1'b1;
            r.last = 1'b1;
            due_bursts.push_back(r);
          end
        end
      end
      OP_TICK: begin
        for (i = 0; i < SLOTS; i++) begin
          if (!slot_live[i]) continue;
          if (slot_st[i].remaining > 16'd1) begin
            slot_st[i].remaining--;
          end else if (batch.size() >= MAX_RESULTS) begin
            slot_st[i].remaining = 16'd1;
          end else begin
            r.message_tag_res = slot_st[i].tag;
            r.priority_res = slot_st[i].prio;
            r.group_id_res = slot_st[i].group;
            r.burst_count = slot_st[i].count;
            r.passed_through = 1'b0;
            r.last = 1'b0;
            batch.push_back(r);
            slot_live[i] = 1'b0;
            slot_st[i].remaining = 16'd0;
          end
        end
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k]) due_bursts.push_back(batch[k]);
      end
      OP_DISCARD: begin
        for (i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  // offers one word after gap idle cycles and predicts it once taken
  task automatic send_word(input in_t w, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    in_data = w;
    do @(posedge clk); while (busy);
    coalesce(w);
  endtask

  function automatic int rand_gap();
    int v;
    v = $urandom_range(0, 99);
    if (v < 60) return 0;
    if (v < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_t random_word();
    in_t w;
    int  r;
    int  v;
    r = $urandom_range(0, 99);
    if (r < 62) w.operation = OP_EVENT;
    else if (r < 92) w.operation = OP_TICK;
    else if (r < 97) w.operation = OP_DISCARD;
    else w.operation = OP_UNUSED;
    w.has_group = ($urandom_range(0, 19) != 0);
    // a small pool of groups so bursts build up and the table fills
    w.group_id = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 23));
    w.priority_req = 2'($urandom_range(0, 3));
    v = $urandom_range(0, 19);
    if (v == 0) w.window_ticks = 16'd0;
    else if (v < 3) w.window_ticks = 16'($urandom_range(0, 65535));
    else w.window_ticks = 16'($urandom_range(1, 6));
    w.message_tag = 16'($urandom_range(0, 65535));
    return w;
  endfunction

  always @(posedge clk) begin
    out_t exp_w;
    if (rst_n && out_valid) begin
      if (due_bursts.size() == 0) begin
        if (bad_words < 10)
          $display("unexpected word: tag %h prio %0d grp %h cnt %0d pt %b last %b",
                   out_data.message_tag_res, out_data.priority_res, out_data.group_id_res,
                   out_data.burst_count, out_data.passed_through, out_data.last);
        bad_words++;
      end else begin
        exp_w = due_bursts.pop_front();
        if (out_data.message_tag_res !== exp_w.message_tag_res ||
            out_data.priority_res !== exp_w.priority_res ||
            out_data.group_id_res !== exp_w.group_id_res ||
            out_data.burst_count !== exp_w.burst_count ||
            out_data.passed_through !== exp_w.passed_through ||
            out_data.last !== exp_w.last) begin
          if (bad_words < 10) begin
            $display("mismatch: exp tag %h prio %0d grp %h cnt %0d pt %b last %b",
                     exp_w.message_tag_res, exp_w.priority_res, exp_w.group_id_res,
                     exp_w.burst_count, exp_w.passed_through, exp_w.last);
            $display("          got tag %h prio %0d grp %h cnt %0d pt %b last %b",
                     out_data.message_tag_res, out_data.priority_res, out_data.group_id_res,
                     out_data.burst_count, out_data.passed_through, out_data.last);
          end
          bad_words++;
        end
      end
    end
  end

  task automatic test_pass_through();
    send_word(mk_word(OP_EVENT, 1'b0, 8'hA5, 2'd0, 16'd100, 16'hFFFF), 0);
    send_word(mk_word(OP_EVENT, 1'b1, 8'hFF, 2'd2, 16'd0, 16'h0001), 0);
    send_word(mk_word(OP_EVENT, 1'b1, 8'h5A, PRIO_CRIT, 16'hFFFF, 16'h0000), 0);
    send_word(mk_word(OP_UNUSED, 1'b1, 8'hFF, 2'd3, 16'hFFFF, 16'hFFFF), 0);
  endtask

  task automatic test_burst_winner();
    send_word(mk_word(OP_DISCARD, 1'b0, 8'h00, 2'd0, 16'd0, 16'd0), 0);
    send_word(mk_word(OP_EVENT, 1'b1, 8'h07, 2'd2, 16'd2, 16'h1111), 0);
    // lower priority joins but does not win, equal priority takes over
    send_word(mk_word(OP_EVENT, 1'b1, 8'h07, 2'd1, 16'd9, 16'h2222), 0);
    send_word(mk_word(OP_EVENT, 1'b1, 8'h07, 2'd2, 16'd1, 16'h3333), 0);
    send_word(mk_word(OP_EVENT, 1'b1, 8'h07, 2'd0, 16'd5, 16'h4444), 0);
    send_word(mk_word(OP_EVENT, 1'b1, 8'h08, 2'd0, 16'd1, 16'h5555), 0);
    send_word(mk_word(OP_TICK, 1'b0, 8'h00, 2'd0, 16'd0, 16'd0), 0);
    send_word(mk_word(OP_TICK, 1'b0, 8'h00, 2'd0, 16'd0, 16'd0), 0);
    send_word(mk_word(OP_EVENT, 1'b1, 8'h09, 2'd1, 16'hFFFF, 16'h6666), 0);
    send_word(mk_word(OP_DISCARD, 1'b0, 8'h00, 2'd0, 16'd0, 16'd0), 0);
    send_word(mk_word(OP_TICK, 1'b0, 8'h00, 2'd0, 16'd0, 16'd0), 0);
  endtask

  task automatic test_full_table();
    int i;
    send_word(mk_word(OP_DISCARD, 1'b0, 8'h00, 2'd0, 16'd0, 16'd0), 0);
    for (i = 0; i < SLOTS; i++)
      send_word(mk_word(OP_EVENT, 1'b1, 8'(8'h10 + i), 2'(i % 3), 16'd1,
                        16'(16'hA000 + i)), 0);
    // no free slot left for this group
    send_word(mk_word(OP_EVENT, 1'b1, 8'hEE, 2'd1, 16'd4, 16'hBEEF), 0);
    send_word(mk_word(OP_TICK, 1'b0, 8'h00, 2'd0, 16'd0, 16'd0), 0);
  endtask

  task automatic test_random_traffic();
    int  i;
    bit  quiet;
    quiet = 1'b0;
    for (i = 0; i < RANDOM_WORDS; i++) begin
      // stretches of back-to-back words between idling ones
      if (i % 50 == 0) quiet = ($urandom_range(0, 2) == 0);
      send_word(random_word(), quiet ? 0 : rand_gap());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    bad_words = 0;
    foreach (slot_live[i]) begin
      slot_live[i] = 1'b0;
      slot_st[i] = '0;
    end
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_pass_through();
    test_burst_winner();
    test_full_table();
    test_random_traffic();

    @(negedge clk);
    start = 1'b0;
    while (due_bursts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (bad_words == 0 && due_bursts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
